// ----- design/uart_8n1_with_rx_fifo_defines.svh -----
// Assertion macros used by the UART top level.
`ifndef UART_8N1_WITH_RX_FIFO_DEFINES_SVH
`define UART_8N1_WITH_RX_FIFO_DEFINES_SVH
`ifndef ASSERT_OFF
`define U8N1_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define U8N1_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8N1_ASSERT(lbl, clk, rstn, prop, msg)
`define U8N1_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/u8n1_pkg.sv -----
// Types and constants shared by the UART receiver, transmitter and top level.
package u8n1_pkg;

	localparam int unsigned DLY_W = 13;
	localparam int unsigned TMR_W = 14;
	localparam logic [TMR_W-1:0] TX_START_EXTRA = TMR_W'(5);

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_RX_CENTER_DELAY = 3'd0,
		REG_RX_BIT_DELAY    = 3'd1,
		REG_RX_STOP_DELAY   = 3'd2,
		REG_TX_BIT_DELAY    = 3'd3,
		REG_INVERT_LOGIC    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       rx_level;
		logic [7:0] tx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_level;
		logic       write_accepted;
		logic       read_valid;
		logic [7:0] read_data;
		logic [5:0] rx_count;
		logic       overflow;
	} out_item_t;

	typedef struct packed {
		logic [DLY_W-1:0] rx_center_delay;
		logic [DLY_W-1:0] rx_bit_delay;
		logic [DLY_W-1:0] rx_stop_delay;
		logic [DLY_W-1:0] tx_bit_delay;
		logic             invert_logic;
	} cfg_t;

	typedef struct packed {
		logic       push;
		logic [7:0] data;
	} rx_push_t;

	typedef struct packed {
		logic accepted;
		logic level;
	} tx_status_t;

endpackage

// ----- design/u8n1_rx.sv -----
// Receive deserializer: start detection, bit sampling and stop wait, one step per tick.
module u8n1_rx (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            level,
	input  u8n1_pkg::cfg_t  cfg,
	output u8n1_pkg::rx_push_t rx_out
);
	import u8n1_pkg::*;

	typedef enum logic [1:0] {
		RX_IDLE = 2'd0,
		RX_DATA = 2'd1,
		RX_STOP = 2'd2
	} rx_phase_t;

	rx_phase_t        phase_q, phase_d;
	logic [TMR_W-1:0] timer_q, timer_d;
	logic [7:0]       shift_q, shift_d;
	logic [2:0]       idx_q, idx_d;

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		shift_d = shift_q;
		idx_d   = idx_q;
		rx_out.push = 1'b0;
		rx_out.data = cfg.invert_logic ? ~shift_q : shift_q;
		if (phase_q == RX_IDLE) begin
			if (cfg.rx_stop_delay != '0 && level == cfg.invert_logic) begin
				phase_d = RX_DATA;
				timer_d = TMR_W'(cfg.rx_center_delay) + TMR_W'(cfg.rx_bit_delay);
				shift_d = '0;
				idx_d   = '0;
			end
		end else if (timer_q != '0) begin
			timer_d = timer_q - 1'b1;
		end else if (phase_q == RX_DATA) begin
			if (level) begin
				shift_d[idx_q] = 1'b1;
			end
			if (idx_q == 3'd7) begin
				idx_d   = '0;
				phase_d = RX_STOP;
				timer_d = TMR_W'(cfg.rx_stop_delay);
			end else begin
				idx_d   = idx_q + 1'b1;
				timer_d = TMR_W'(cfg.rx_bit_delay);
			end
		end else begin
			// End of the stop wait: hand the byte to the FIFO and go idle.
			rx_out.push = en;
			phase_d     = RX_IDLE;
			timer_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RX_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			idx_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			shift_q <= shift_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ----- design/u8n1_tx.sv -----
// Transmit serializer: start bit, eight data bits LSB first and an idle gap.
module u8n1_tx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               write_req,
	input  logic [7:0]         tx_byte,
	input  u8n1_pkg::cfg_t     cfg,
	output u8n1_pkg::tx_status_t tx_out
);
	import u8n1_pkg::*;

	typedef enum logic [1:0] {
		TX_IDLE  = 2'd0,
		TX_START = 2'd1,
		TX_DATA  = 2'd2,
		TX_GAP   = 2'd3
	} tx_phase_t;

	tx_phase_t        phase_q, phase_d;
	logic [TMR_W-1:0] timer_q, timer_d;
	logic [7:0]       shift_q, shift_d;
	logic [2:0]       idx_q, idx_d;
	logic [TMR_W-1:0] reload;
	logic             bit_lvl;

	// A zero bit delay mid-frame still lets each remaining bit last one tick.
	assign reload = (cfg.tx_bit_delay != '0) ? TMR_W'(cfg.tx_bit_delay) : TMR_W'(1);

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		shift_d = shift_q;
		idx_d   = idx_q;
		tx_out.accepted = 1'b0;
		if (write_req && phase_q == TX_IDLE && cfg.tx_bit_delay != '0) begin
			phase_d = TX_START;
			timer_d = TMR_W'(cfg.tx_bit_delay) + TX_START_EXTRA;
			shift_d = tx_byte;
			idx_d   = '0;
			tx_out.accepted = 1'b1;
		end else if (phase_q != TX_IDLE) begin
			if (timer_q > TMR_W'(1)) begin
				timer_d = timer_q - 1'b1;
			end else begin
				case (phase_q)
					TX_START: begin
						phase_d = TX_DATA;
						idx_d   = '0;
						timer_d = reload;
					end
					TX_DATA: begin
						if (idx_q == 3'd7) begin
							idx_d   = '0;
							phase_d = TX_GAP;
						end else begin
							idx_d = idx_q + 1'b1;
						end
						timer_d = reload;
					end
					default: begin
						phase_d = TX_IDLE;
						timer_d = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		case (phase_d)
			TX_START: bit_lvl = 1'b0;
			TX_DATA:  bit_lvl = shift_d[idx_d];
			default:  bit_lvl = 1'b1;
		endcase
		tx_out.level = bit_lvl ^ cfg.invert_logic;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= TX_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			idx_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			shift_q <= shift_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ----- design/uart_8n1_with_rx_fifo.sv -----
// Top level of the 8N1 UART with its receive FIFO and register port.
//
// Usage: every item on the input channel (item, item_valid, item_stall) is one
// oversampling tick of the serial line. It carries the sampled receive level and
// a command: a plain tick, a byte to transmit, or a read from the receive FIFO.
// Each accepted item produces exactly one result item on the output channel
// (result, result_valid, result_stall) with the transmit level, the write and
// read status, the popped byte, the FIFO fill and the sticky overflow flag.
// The result of an item is registered at the edge that accepts it. The block
// takes one item every clock while item_stall is low; the FIFO memory has a
// single registered read port and one write port, and a pop and a push in the
// same tick always address different entries, so no interlock is needed.
// When the receiver stalls, the waiting result moves to a skid register and one
// more item is still taken; item_stall rises only while the skid register is
// full and drops as soon as the output side takes a result.
// Reset clears the FIFO pointers, the overflow flag, both serial state machines
// and all delay registers, which disables both directions until they are set.
// The FIFO memory is not cleared; an entry is only read after it is written.
// The user must write delay registers via APB only while idle; it is not enforced.
`include "uart_8n1_with_rx_fifo_defines.svh"
module uart_8n1_with_rx_fifo #(
	parameter int unsigned FIFO_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  u8n1_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output u8n1_pkg::out_item_t  result
);
	import u8n1_pkg::*;

	localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W  = (AW+1)'(FIFO_DEPTH);

	// Configuration registers.
	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_RX_CENTER_DELAY: cfg_q.rx_center_delay <= pwdata[DLY_W-1:0];
				REG_RX_BIT_DELAY:    cfg_q.rx_bit_delay    <= pwdata[DLY_W-1:0];
				REG_RX_STOP_DELAY:   cfg_q.rx_stop_delay   <= pwdata[DLY_W-1:0];
				REG_TX_BIT_DELAY:    cfg_q.tx_bit_delay    <= pwdata[DLY_W-1:0];
				REG_INVERT_LOGIC:    cfg_q.invert_logic    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RX_CENTER_DELAY: prdata = 32'(cfg_q.rx_center_delay);
			REG_RX_BIT_DELAY:    prdata = 32'(cfg_q.rx_bit_delay);
			REG_RX_STOP_DELAY:   prdata = 32'(cfg_q.rx_stop_delay);
			REG_TX_BIT_DELAY:    prdata = 32'(cfg_q.tx_bit_delay);
			REG_INVERT_LOGIC:    prdata = 32'(cfg_q.invert_logic);
			default:             prdata = '0;
		endcase
	end

	// Input handshake and the output stage with its skid register.
	out_item_t res_s1, skid_q, res_d, res_out_s1;
	logic      vld_s1, skid_vld_q;
	logic      accept;

	assign item_stall   = skid_vld_q;
	assign accept       = item_valid && !item_stall;
	assign result_valid = vld_s1 || skid_vld_q;

	// Serial engines; both advance exactly once per accepted item.
	rx_push_t   rx_out;
	tx_status_t tx_out;

	u8n1_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.level  (item.rx_level),
		.cfg    (cfg_q),
		.rx_out (rx_out)
	);

	u8n1_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.write_req (accept && item.cmd == CMD_WRITE),
		.tx_byte   (item.tx_byte),
		.cfg       (cfg_q),
		.tx_out    (tx_out)
	);

	// Receive FIFO: a ring of FIFO_DEPTH entries that holds at most one less.
	logic [7:0]    rx_mem_q [FIFO_DEPTH];
	logic [7:0]    rd_s1;
	logic [AW-1:0] head_q, tail_q, head_d, tail_d, head_inc, tail_inc;
	logic          overflow_q, overflow_d;
	logic          pop, mem_wr;
	logic [AW:0]   fill;

	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	// The pop is ordered ahead of the push, so fullness is judged on the new head.
	assign pop        = accept && item.cmd == CMD_READ && head_q != tail_q;
	assign head_d     = pop ? head_inc : head_q;
	assign mem_wr     = rx_out.push && tail_inc != head_d;
	assign tail_d     = mem_wr ? tail_inc : tail_q;
	assign overflow_d = overflow_q || (rx_out.push && tail_inc == head_d);

	assign fill = (tail_d >= head_d)
		? ({1'b0, tail_d} - {1'b0, head_d})
		: ({1'b0, tail_d} + DEPTH_W - {1'b0, head_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			overflow_q <= overflow_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			rx_mem_q[tail_q] <= rx_out.data;
		end
	end

	// Read data is held until the next pop, so a stalled result keeps its byte.
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_s1 <= rx_mem_q[head_q];
		end
	end

	// Result of the item being accepted; the popped byte joins it from the read register.
	always_comb begin
		res_d.tx_level       = tx_out.level;
		res_d.write_accepted = tx_out.accepted;
		res_d.read_valid     = pop;
		res_d.read_data      = '0;
		res_d.rx_count       = 6'(fill);
		res_d.overflow       = overflow_d;
	end

	always_comb begin
		res_out_s1 = res_s1;
		res_out_s1.read_data = res_s1.read_valid ? rd_s1 : 8'h00;
	end

	assign result = skid_vld_q ? skid_q : res_out_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!result_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (accept) begin
			vld_s1 <= 1'b1;
			if (vld_s1 && result_stall) begin
				skid_vld_q <= 1'b1;
			end
		end else if (vld_s1 && !result_stall) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
			if (vld_s1 && result_stall) begin
				skid_q <= res_out_s1;
			end
		end
	end

	// The skid register only ever holds an older result than the output stage.
	`U8N1_ASSERT(a_skid_behind_s1, clk, arst_n, skid_vld_q |-> vld_s1, "skid full without stage")
	// Input stalls only while a result is waiting on the output.
	`U8N1_ASSERT(a_stall_has_result, clk, arst_n, item_stall |-> result_valid, "stall with no result")
	// Overflow is sticky until reset.
	`U8N1_ASSERT(a_overflow_sticky, clk, arst_n, overflow_q |=> overflow_q, "overflow flag cleared")
	// Ring pointers stay inside the memory for any depth.
	`U8N1_ASSERT(a_ptr_range, clk, arst_n, (head_q <= LAST_IDX) && (tail_q <= LAST_IDX), "FIFO pointer out of range")
	// A pop and a push never address the same entry in one cycle.
	`U8N1_ASSERT(a_no_rw_clash, clk, arst_n, (pop && mem_wr) |-> (head_q != tail_q), "FIFO read and write clash")

endmodule

// ----- tb/uart_tick_checker.sv -----
// Checker that mirrors the UART tick behavior and compares every result item.
`timescale 1ns / 1ps
module uart_tick_checker #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                item_valid,
	input  logic                item_stall,
	input  u8n1_pkg::in_item_t  item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  u8n1_pkg::out_item_t result,
	output int                  mismatches,
	output int                  waiting
);
	import u8n1_pkg::*;

	typedef enum logic [1:0] {RX_IDLE, RX_BITS, RX_STOP_WAIT} rx_state_t;
	typedef enum logic [1:0] {TX_IDLE, TX_START_BIT, TX_BITS, TX_GAP} tx_state_t;

	cfg_t              cfg;
	logic [7:0]        fifo_mem [DEPTH];
	int unsigned       head, tail;
	logic              overflow_seen;
	rx_state_t         rx_state;
	logic [TMR_W-1:0]  rx_wait;
	logic [7:0]        rx_byte;
	logic [2:0]        rx_pos;
	tx_state_t         tx_state;
	logic [TMR_W-1:0]  tx_wait;
	logic [7:0]        tx_byte;
	logic [2:0]        tx_pos;
	out_item_t         due_results [$];
	int                mismatch_count = 0;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
	endtask

	// Advances the mirrored UART by one tick and returns the result it shows.
	function automatic out_item_t step_uart(in_item_t it);
		out_item_t   r;
		int unsigned nxt;
		logic [7:0]  got;
		logic        line;
		r = '0;
		// A read pops before this tick's receive push.
		if (it.cmd == CMD_READ && head != tail) begin
			r.read_valid = 1'b1;
			r.read_data = fifo_mem[head];
			head = (head + 1) % DEPTH;
		end
		case (rx_state)
			RX_IDLE: begin
				if (cfg.rx_stop_delay != '0 && it.rx_level == cfg.invert_logic) begin
					rx_state = RX_BITS;
					rx_wait = TMR_W'(cfg.rx_center_delay) + TMR_W'(cfg.rx_bit_delay);
					rx_byte = '0;
					rx_pos = '0;
				end
			end
			default: begin
				if (rx_wait != '0) begin
					rx_wait--;
				end else if (rx_state == RX_BITS) begin
					rx_byte[rx_pos] = it.rx_level;
					if (rx_pos == 3'd7) begin
						rx_pos = '0;
						rx_state = RX_STOP_WAIT;
						rx_wait = TMR_W'(cfg.rx_stop_delay);
					end else begin
						rx_pos++;
						rx_wait = TMR_W'(cfg.rx_bit_delay);
					end
				end else begin
					got = cfg.invert_logic ? ~rx_byte : rx_byte;
					nxt = (tail + 1) % DEPTH;
					if (nxt != head) begin
						fifo_mem[tail] = got;
						tail = nxt;
					end else begin
						overflow_seen = 1'b1;
					end
					rx_state = RX_IDLE;
					rx_wait = '0;
				end
			end
		endcase
		if (it.cmd == CMD_WRITE && tx_state == TX_IDLE && cfg.tx_bit_delay != '0) begin
			tx_state = TX_START_BIT;
			tx_wait = TMR_W'(cfg.tx_bit_delay) + TX_START_EXTRA;
			tx_byte = it.tx_byte;
			tx_pos = '0;
			r.write_accepted = 1'b1;
		end else if (tx_state != TX_IDLE) begin
			if (tx_wait > 1) begin
				tx_wait--;
			end else begin
				case (tx_state)
					TX_START_BIT: begin
						tx_state = TX_BITS;
						tx_pos = '0;
					end
					TX_BITS: begin
						if (tx_pos == 3'd7) begin
							tx_pos = '0;
							tx_state = TX_GAP;
						end else begin
							tx_pos++;
						end
					end
					default: begin
						tx_state = TX_IDLE;
						tx_wait = '0;
					end
				endcase
				// A bit delay cleared mid-frame makes each remaining bit one tick long.
				if (tx_state != TX_IDLE)
					tx_wait = (cfg.tx_bit_delay != '0) ? TMR_W'(cfg.tx_bit_delay) : TMR_W'(1);
			end
		end
		case (tx_state)
			TX_START_BIT: line = 1'b0;
			TX_BITS:      line = tx_byte[tx_pos];
			default:      line = 1'b1;
		endcase
		r.tx_level = line ^ cfg.invert_logic;
		r.rx_count = 6'((tail + DEPTH - head) % DEPTH);
		r.overflow = overflow_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			cfg = '0;
			head = 0;
			tail = 0;
			overflow_seen = 1'b0;
			rx_state = RX_IDLE;
			rx_wait = '0;
			rx_byte = '0;
			rx_pos = '0;
			tx_state = TX_IDLE;
			tx_wait = '0;
			tx_byte = '0;
			tx_pos = '0;
			due_results.delete();
			waiting <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					report("result with nothing due", 32'(result), '0);
				end else begin
					want = due_results.pop_front();
					if (result.tx_level !== want.tx_level)
						report("tx_level", 32'(result.tx_level), 32'(want.tx_level));
					if (result.write_accepted !== want.write_accepted)
						report("write_accepted", 32'(result.write_accepted),
							32'(want.write_accepted));
					if (result.read_valid !== want.read_valid)
						report("read_valid", 32'(result.read_valid), 32'(want.read_valid));
					if (result.read_data !== want.read_data)
						report("read_data", 32'(result.read_data), 32'(want.read_data));
					if (result.rx_count !== want.rx_count)
						report("rx_count", 32'(result.rx_count), 32'(want.rx_count));
					if (result.overflow !== want.overflow)
						report("overflow", 32'(result.overflow), 32'(want.overflow));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_RX_CENTER_DELAY: cfg.rx_center_delay = pwdata[DLY_W-1:0];
					REG_RX_BIT_DELAY:    cfg.rx_bit_delay = pwdata[DLY_W-1:0];
					REG_RX_STOP_DELAY:   cfg.rx_stop_delay = pwdata[DLY_W-1:0];
					REG_TX_BIT_DELAY:    cfg.tx_bit_delay = pwdata[DLY_W-1:0];
					REG_INVERT_LOGIC:    cfg.invert_logic = pwdata[0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				due_results.push_back(step_uart(item));
			waiting <= due_results.size();
		end
		mismatches <= mismatch_count;
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the UART testbench: clock, reset, register setup, tick stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import u8n1_pkg::*;

	// Generous bound on the whole run, a few times the slowest legal run.
	localparam int unsigned LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	in_item_t    item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;
	int          mismatches;
	int          waiting;

	// Stimulus state. The line shape follows the settings last written, so frames
	// sent by the generator line up with the receiver's sampling points.
	int unsigned cycle_count = 0;
	int unsigned sent = 0;
	int unsigned phase_len = 0;
	int unsigned read_pct = 0;
	int unsigned calm_len = 0;
	logic        calm = 1'b0;
	int unsigned bit_cfg = 0;
	int unsigned stop_cfg = 0;
	logic        line_invert = 1'b0;

	uart_8n1_with_rx_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	uart_tick_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The result side stalls at random about a fifth of the time, except in calm stretches
	// where both sides run back to back.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 21);
	end

	// Offers one item, possibly after random idle cycles, and returns after the edge
	// that accepted it, once item_stall is low. The payload holds steady while stalled.
	task automatic send_item(cmd_t c, logic lvl, logic [7:0] b);
		while (!calm && $urandom_range(99) < 21) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= in_item_t'{c, lvl, b};
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// One line tick with a random command mix; reads are weighted per phase so
	// some phases drain the FIFO and others let it fill up and overflow.
	task automatic send_tick(logic lvl);
		int unsigned r;
		cmd_t c;
		r = $urandom_range(99);
		if (r < read_pct)
			c = CMD_READ;
		else if (r < read_pct + 10)
			c = CMD_WRITE;
		else if (r < read_pct + 14)
			c = CMD_NONE;
		else
			c = CMD_TICK;
		calm <= (sent < calm_len);
		send_item(c, lvl, 8'($urandom));
		sent++;
	endtask

	// A well-formed 8N1 frame with a random byte: idle, start, eight data bits
	// LSB first and a stop level long enough to cover the stop wait. Each bit is
	// held one bit period so the receiver samples inside it.
	task automatic send_frame();
		logic [9:0]  symbols;
		int unsigned hold;
		int unsigned i;
		int unsigned k;
		symbols = {1'b1, 8'($urandom), 1'b0};
		repeat ($urandom_range(1, 3))
			if (sent < phase_len)
				send_tick(!line_invert);
		for (i = 0; i < 10; i++) begin
			hold = (i == 9) ? stop_cfg + 2 : bit_cfg + 1;
			for (k = 0; k < hold && sent < phase_len; k++)
				send_tick(symbols[i] ^ line_invert);
		end
	endtask

	// Random line levels: false starts and broken frames.
	task automatic send_noise();
		repeat ($urandom_range(1, 12))
			if (sent < phase_len)
				send_tick(1'($urandom));
	endtask

	// Waits until every result due has been taken, with the input side idle.
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting != 0);
	endtask

	// Setup and access cycle; the register is written at the access edge.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// Registers are only written with nothing in flight. The serial state
	// machines may still be mid-frame, which is intended: new delays take
	// effect at the next timer load.
	task automatic set_config(int unsigned center, int unsigned bitd, int unsigned stop,
			int unsigned txd, logic inv);
		drain();
		write_reg(REG_RX_CENTER_DELAY, center);
		write_reg(REG_RX_BIT_DELAY, bitd);
		write_reg(REG_RX_STOP_DELAY, stop);
		write_reg(REG_TX_BIT_DELAY, txd);
		write_reg(REG_INVERT_LOGIC, 32'(inv));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bit_cfg = bitd;
		stop_cfg = stop;
		line_invert = inv;
	endtask

	task automatic run_phase(int unsigned center, int unsigned bitd, int unsigned stop,
			int unsigned txd, logic inv, int unsigned reads, int unsigned len,
			int unsigned calm_items);
		set_config(center, bitd, stop, txd, inv);
		read_pct = reads;
		phase_len = len;
		calm_len = calm_items;
		sent = 0;
		while (sent < len) begin
			if ($urandom_range(99) < 80)
				send_frame();
			else
				send_noise();
		end
		calm <= 1'b0;
	endtask

	// Watchdog: a run that never drains ends here as a failure.
	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [7:0] frame_byte;
		int unsigned i;
		frame_byte = 8'h81;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset every delay is zero, so both directions are off:
		// the write is refused, the read finds nothing, and a low line is no start.
		send_item(CMD_TICK, 1'b0, 8'h00);
		send_item(CMD_WRITE, 1'b1, 8'hFF);
		send_item(CMD_READ, 1'b0, 8'hFF);
		send_item(CMD_NONE, 1'b1, 8'h00);

		// Fastest timing. The first write starts a frame, the second is refused
		// because the transmitter is busy.
		set_config(0, 0, 1, 1, 1'b0);
		send_item(CMD_WRITE, 1'b1, 8'hA5);
		send_item(CMD_WRITE, 1'b1, 8'h5A);

		// Clearing the bit delay mid-frame: the rest of the frame runs with
		// one-tick bits, and new writes are refused as transmit is now off.
		set_config(0, 0, 1, 0, 1'b0);
		send_item(CMD_WRITE, 1'b1, 8'h00);

		// One received byte. The read on the push tick sees an empty FIFO since
		// the pop comes first; the next read returns the byte.
		send_item(CMD_TICK, 1'b0, 8'h00);
		for (i = 0; i < 8; i++)
			send_item(CMD_TICK, frame_byte[i], 8'hFF);
		send_item(CMD_TICK, 1'b1, 8'h00);
		send_item(CMD_READ, 1'b1, 8'h00);
		send_item(CMD_READ, 1'b1, 8'h00);

		// Random phases: center, bit, stop, tx delays, inversion, read share,
		// length in ticks and how many leading ticks run without idling.
		run_phase(0, 0, 1, 1, 1'b0, 30, 150, 0);
		run_phase(1, 2, 2, 3, 1'b1, 20, 200, 0);
		// No reads here, so the FIFO fills past its limit and overflow sets.
		run_phase(0, 0, 1, 2, 1'b0, 0, 900, 400);
		// Both directions off while the FIFO drains.
		run_phase(0, 1, 0, 0, 1'b0, 50, 60, 0);
		run_phase(2, 3, 3, 4, 1'b1, 40, 120, 0);
		// Every delay at its maximum; frames are left in progress at the end.
		run_phase(8191, 8191, 8191, 8191, 1'b1, 10, 100, 0);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/u8n1_pkg.sv
design/u8n1_rx.sv
design/u8n1_tx.sv
design/uart_8n1_with_rx_fifo.sv
tb/uart_tick_checker.sv
tb/testbench.sv
